>>> design/bmsp_pkg.sv
// Shared constants for the bilinear map and sphere projection unit.
`default_nettype none
package bmsp_pkg;

  localparam int NumTrees    = 64;
  localparam int NumVertices = 256;
  localparam int Corners     = 4;
  localparam int Axes        = 3;

  localparam int TreeW  = 6;
  localparam int VertW  = 8;
  localparam int CoordW = 24;
  localparam int EtaW   = 17;
  localparam int WgtW   = 33;   // UQ1.32 weight, one included
  localparam int ProdW  = 58;   // signed coordinate times unsigned weight
  localparam int DiffW  = 25;   // coordinate minus one half
  localparam int SqW    = 48;   // squared norm
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 24;
  localparam int NumW   = 57;   // scaled numerator with rounding term

  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_VERT_WR   = 2'd1;
  localparam logic [1:0] OP_CORNER_WR = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;

  localparam logic [EtaW-1:0]   ETA_ONE     = 17'd65536;
  localparam logic [CoordW-1:0] RADIUS_RST  = 24'd65536;
  localparam logic [DiffW-1:0]  HALF_Q16    = 25'd32768;
  localparam logic [ProdW-1:0]  ROUND_HALF  = 58'h0_8000_0000;
  localparam logic [CoordW-1:0] S24_MAX     = 24'h7F_FFFF;
  localparam logic [CoordW-1:0] S24_MIN     = 24'h80_0000;

endpackage
`default_nettype wire

>>> design/bilinear_map_sphere_projection_unit.sv
// Bilinear tree-to-space map with projection onto a sphere, fully pipelined.
//
// Input channel (in_*): one word per item. in_tuser carries the operation:
// map a point, write a vertex coordinate or write a tree corner entry.
// Table writes take effect in order with map words and give no result.
// Result channel (out_*): one word per map item, coordinates in tdata and
// status in tuser. Configuration channel (cfg_*): index 0 mode, 1 radius;
// it is always ready; the user must write it only while the unit is idle,
// which the unit itself does not enforce. Throughput is one word per cycle
// while the receiver does not stall. A map word passes the front-end stages,
// the 32-stage square-root pipe and the 24-stage divider pipe.
// The whole pipe advances together; when out_tready is low with a result
// waiting, every stage holds and in_tready falls, so nothing is lost.
// Reset clears all stage valid bits, sets mode to plain mapping and radius
// to one. The vertex and corner tables are not cleared and must be written
// before they are read.
`default_nettype none
module bilinear_map_sphere_projection_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tree[5:0], corner[7:6], vertex_index[15:8], component[17:16],
  // vertex_value[41:18], eta_x[58:42], eta_y[75:59], zero fill above
  input  wire logic [79:0] in_tdata,
  // operation[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_x[23:0], out_y[47:24], out_z[71:48]
  output logic [71:0]      out_tdata,
  // status[1:0]
  output logic [1:0]       out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import bmsp_pkg::*;

  logic en;
  logic [1:0] in_op;
  logic [TreeW-1:0] in_tree;
  logic [1:0] in_corner;
  logic [VertW-1:0] in_vidx;
  logic [1:0] in_comp;
  logic [CoordW-1:0] in_val;
  logic [EtaW-1:0] in_ex, in_ey, ex_clamp, ey_clamp;

  logic mode_r;
  logic [CoordW-1:0] radius_r;

  // tables
  logic [VertW-1:0]  cmem [Corners][NumTrees];
  logic [CoordW-1:0] vmem [Corners][Axes][NumVertices];

  // stage 1
  logic s1_valid_r;
  logic [1:0] s1_op_r;
  logic [VertW-1:0] s1_vidx_r;
  logic [1:0] s1_comp_r;
  logic [CoordW-1:0] s1_val_r;
  logic [EtaW-1:0] s1_ex_r, s1_ey_r;
  logic [VertW-1:0] cr_r [Corners];
  logic [EtaW-1:0] omx, omy;
  logic [2*EtaW-1:0] w_nxt [Corners];

  // stage 2 .. 6
  logic s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;
  logic [WgtW-1:0] w_r [Corners];
  logic [CoordW-1:0] vd_r [Corners][Axes];
  logic signed [ProdW-1:0] prod_r [Axes][Corners];
  logic signed [ProdW-1:0] ps_r [Axes][2];
  logic signed [ProdW-1:0] acc_nxt [Axes];
  logic [CoordW-1:0] p_r [Axes];
  logic signed [DiffW-1:0] d_nxt [Axes];
  logic signed [2*DiffW-1:0] sq_nxt [Axes];
  logic signed [DiffW-1:0] d_r [Axes];
  logic [SqW-1:0] sq_r [Axes];
  logic [SqW-1:0] n2_nxt;

  // square root pipe
  logic        sqv_r [SqrtSteps+1];
  logic        sqz_r [SqrtSteps+1];
  logic [63:0] sq_rem_r [SqrtSteps+1];
  logic [63:0] sq_res_r [SqrtSteps+1];
  logic [63:0] sq_rem_nxt [SqrtSteps+1];
  logic [63:0] sq_res_nxt [SqrtSteps+1];
  logic signed [DiffW-1:0] sqd_r [SqrtSteps+1][Axes];

  // scale and divider pipe
  logic mv_r, mz_r;
  logic [31:0] norm_r;
  logic [2*CoordW-1:0] mg_r [Axes];
  logic signed [DiffW-1:0] md_r [Axes];
  logic [CoordW-1:0] mag_nxt [Axes];
  logic        dvv_r [DivSteps+1];
  logic        dvz_r [DivSteps+1];
  logic [31:0] dvn_r [DivSteps+1];
  logic [NumW-1:0] dvr_r [DivSteps+1][Axes];
  logic [NumW-1:0] dvr_nxt [DivSteps+1][Axes];
  logic [DivSteps-1:0] dvq_r [DivSteps+1][Axes];
  logic [DivSteps-1:0] dvq_nxt [DivSteps+1][Axes];
  logic signed [DiffW-1:0] dvd_r [DivSteps+1][Axes];

  // output register
  logic out_valid_r;
  logic [CoordW-1:0] oc_nxt [Axes];
  logic [CoordW-1:0] oc_r [Axes];
  logic [1:0] st_nxt, st_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  assign in_op     = in_tuser;
  assign in_tree   = in_tdata[5:0];
  assign in_corner = in_tdata[7:6];
  assign in_vidx   = in_tdata[15:8];
  assign in_comp   = in_tdata[17:16];
  assign in_val    = in_tdata[41:18];
  assign in_ex     = in_tdata[58:42];
  assign in_ey     = in_tdata[75:59];
  assign ex_clamp  = (in_ex > ETA_ONE) ? ETA_ONE : in_ex;
  assign ey_clamp  = (in_ey > ETA_ONE) ? ETA_ONE : in_ey;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      radius_r <= RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_data[0];
        REG_RADIUS: radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // corner table: written at acceptance, read for the accepted word
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_tvalid && in_op == OP_CORNER_WR) begin
        cmem[in_corner][in_tree] <= in_vidx;
      end
      for (int k = 0; k < Corners; k++) begin
        cr_r[k] <= cmem[k][in_tree];
      end
    end
  end

  // vertex table: one copy per corner so each is read at a single address;
  // writes happen in stage 1 to keep order with map words
  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid_r && s1_op_r == OP_VERT_WR && s1_comp_r != 2'd3) begin
        for (int k = 0; k < Corners; k++) begin
          vmem[k][s1_comp_r][s1_vidx_r] <= s1_val_r;
        end
      end
      for (int k = 0; k < Corners; k++) begin
        for (int j = 0; j < Axes; j++) begin
          vd_r[k][j] <= vmem[k][j][cr_r[k]];
        end
      end
    end
  end

  // front end combinational terms
  always_comb begin
    omx = ETA_ONE - s1_ex_r;
    omy = ETA_ONE - s1_ey_r;
    w_nxt[0] = omx * omy;
    w_nxt[1] = s1_ex_r * omy;
    w_nxt[2] = omx * s1_ey_r;
    w_nxt[3] = s1_ex_r * s1_ey_r;
    for (int j = 0; j < Axes; j++) begin
      acc_nxt[j] = ps_r[j][0] + ps_r[j][1] + $signed(ROUND_HALF);
      d_nxt[j]   = $signed({p_r[j][CoordW-1], p_r[j]}) - $signed(HALF_Q16);
      sq_nxt[j]  = d_nxt[j] * d_nxt[j];
    end
    n2_nxt = sq_r[0] + sq_r[1] + sq_r[2];
  end

  // square-root stages, one result bit each
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    sq_rem_nxt[0] = '0;
    sq_res_nxt[0] = '0;
    for (int i = 0; i < SqrtSteps; i++) begin
      bitv  = 64'd1 << (62 - 2 * i);
      trial = sq_res_r[i] + bitv;
      if (sq_rem_r[i] >= trial) begin
        sq_rem_nxt[i+1] = sq_rem_r[i] - trial;
        sq_res_nxt[i+1] = (sq_res_r[i] >> 1) + bitv;
      end else begin
        sq_rem_nxt[i+1] = sq_rem_r[i];
        sq_res_nxt[i+1] = sq_res_r[i] >> 1;
      end
    end
  end

  // magnitudes and restoring divider stages, one quotient bit each
  always_comb begin
    logic [NumW-1:0] dsh;
    for (int j = 0; j < Axes; j++) begin
      mag_nxt[j] = sqd_r[SqrtSteps][j][DiffW-1] ? CoordW'(-sqd_r[SqrtSteps][j])
                                                  : CoordW'(sqd_r[SqrtSteps][j]);
      dvr_nxt[0][j] = '0;
      dvq_nxt[0][j] = '0;
    end
    for (int i = 0; i < DivSteps; i++) begin
      dsh = {{(NumW-32){1'b0}}, dvn_r[i]} << (DivSteps - 1 - i);
      for (int j = 0; j < Axes; j++) begin
        dvq_nxt[i+1][j] = dvq_r[i][j];
        if (dvr_r[i][j] >= dsh) begin
          dvr_nxt[i+1][j] = dvr_r[i][j] - dsh;
          dvq_nxt[i+1][j][DivSteps-1-i] = 1'b1;
        end else begin
          dvr_nxt[i+1][j] = dvr_r[i][j];
        end
      end
    end
  end

  // final sign, saturation and status
  always_comb begin
    logic [DiffW-1:0] pv;
    logic [DivSteps-1:0] q;
    logic sat;
    sat = 1'b0;
    for (int j = 0; j < Axes; j++) begin
      pv = dvd_r[DivSteps][j] + HALF_Q16;
      q  = dvq_r[DivSteps][j];
      if (!mode_r) begin
        oc_nxt[j] = pv[CoordW-1:0];
      end else if (dvz_r[DivSteps]) begin
        oc_nxt[j] = '0;
      end else if (!dvd_r[DivSteps][j][DiffW-1]) begin
        if (q > S24_MAX) begin
          oc_nxt[j] = S24_MAX;
          sat = 1'b1;
        end else begin
          oc_nxt[j] = q;
        end
      end else begin
        if (q > S24_MIN) begin
          oc_nxt[j] = S24_MIN;
          sat = 1'b1;
        end else begin
          oc_nxt[j] = -q;
        end
      end
    end
    if (mode_r && dvz_r[DivSteps]) begin
      st_nxt = ST_ZERO;
    end else if (sat) begin
      st_nxt = ST_SAT;
    end else begin
      st_nxt = ST_OK;
    end
  end

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= SqrtSteps; i++) sqv_r[i] <= 1'b0;
      for (int i = 0; i <= DivSteps; i++) dvv_r[i] <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_tvalid;
      // drop write and unused words after the tables
      s2_valid_r  <= s1_valid_r && s1_op_r == OP_MAP;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      sqv_r[0]    <= s6_valid_r;
      for (int i = 0; i < SqrtSteps; i++) sqv_r[i+1] <= sqv_r[i];
      mv_r        <= sqv_r[SqrtSteps];
      dvv_r[0]    <= mv_r;
      for (int i = 0; i < DivSteps; i++) dvv_r[i+1] <= dvv_r[i];
      out_valid_r <= dvv_r[DivSteps];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r   <= in_op;
      s1_vidx_r <= in_vidx;
      s1_comp_r <= in_comp;
      s1_val_r  <= in_val;
      s1_ex_r   <= ex_clamp;
      s1_ey_r   <= ey_clamp;
      for (int k = 0; k < Corners; k++) w_r[k] <= w_nxt[k][WgtW-1:0];
      for (int j = 0; j < Axes; j++) begin
        for (int k = 0; k < Corners; k++) begin
          prod_r[j][k] <= $signed(vd_r[k][j]) * $signed({1'b0, w_r[k]});
        end
        ps_r[j][0] <= prod_r[j][0] + prod_r[j][1];
        ps_r[j][1] <= prod_r[j][2] + prod_r[j][3];
        // round half up, drop the 32 fraction bits
        p_r[j]     <= acc_nxt[j][55:32];
        d_r[j]     <= d_nxt[j];
        sq_r[j]    <= sq_nxt[j][SqW-1:0];
        sqd_r[0][j] <= d_r[j];
      end
      sq_rem_r[0] <= {n2_nxt, 16'd0};
      sq_res_r[0] <= '0;
      sqz_r[0]    <= (n2_nxt == '0);
      for (int i = 0; i < SqrtSteps; i++) begin
        sq_rem_r[i+1] <= sq_rem_nxt[i+1];
        sq_res_r[i+1] <= sq_res_nxt[i+1];
        sqz_r[i+1]    <= sqz_r[i];
        for (int j = 0; j < Axes; j++) sqd_r[i+1][j] <= sqd_r[i][j];
      end
      norm_r <= sq_res_r[SqrtSteps][31:0];
      mz_r   <= sqz_r[SqrtSteps];
      for (int j = 0; j < Axes; j++) begin
        mg_r[j] <= radius_r * mag_nxt[j];
        md_r[j] <= sqd_r[SqrtSteps][j];
        dvr_r[0][j] <= {1'b0, mg_r[j], 8'd0} + {{(NumW-31){1'b0}}, norm_r[31:1]};
        dvq_r[0][j] <= dvq_nxt[0][j] | '0;
        dvd_r[0][j] <= md_r[j];
      end
      dvn_r[0] <= norm_r;
      dvz_r[0] <= mz_r;
      for (int i = 0; i < DivSteps; i++) begin
        dvn_r[i+1] <= dvn_r[i];
        dvz_r[i+1] <= dvz_r[i];
        for (int j = 0; j < Axes; j++) begin
          dvr_r[i+1][j] <= dvr_nxt[i+1][j];
          dvq_r[i+1][j] <= dvq_nxt[i+1][j];
          dvd_r[i+1][j] <= dvd_r[i][j];
        end
      end
      for (int j = 0; j < Axes; j++) oc_r[j] <= oc_nxt[j];
      st_r <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oc_r[2], oc_r[1], oc_r[0]};
  assign out_tuser  = st_r;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ZERO |-> out_tdata == '0)
    else $error("zero-norm result carries non-zero coordinates");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SAT |->
      (oc_r[0] == S24_MAX || oc_r[0] == S24_MIN ||
       oc_r[1] == S24_MAX || oc_r[1] == S24_MIN ||
       oc_r[2] == S24_MAX || oc_r[2] == S24_MIN))
    else $error("saturated status without a clipped coordinate");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

endmodule
`default_nettype wire

>>> test/bmsp_checker.sv
// Checker for the bilinear map unit: predicts each mapped point and compares the results.
module bmsp_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmsp_pkg::*;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [1:0]        status;
  } point_t;

  point_t            mapped_q[$];
  logic [CoordW-1:0] vert_tab [NumVertices*Axes];
  logic [VertW-1:0]  corner_tab [NumTrees*Corners];
  logic              proj_mode;
  logic [CoordW-1:0] radius_q;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp24(longint v, inout bit sat);
    if (v > 64'sd8388607) begin
      sat = 1'b1;
      return 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      sat = 1'b1;
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic point_t map_point(logic [79:0] word);
    longint          ex, ey, acc, q;
    longint          w[4], p[3], d[3], r[3];
    longint unsigned n2, norm, mag, num;
    int              vt[4];
    bit              sat;
    logic [1:0]      st;
    point_t          pt;
    ex  = longint'(word[58:42]);
    ey  = longint'(word[75:59]);
    sat = 1'b0;
    st  = ST_OK;
    // clamp eta to one
    if (ex > 65536) ex = 65536;
    if (ey > 65536) ey = 65536;
    for (int k = 0; k < 4; k++) vt[k] = int'(corner_tab[Corners*word[5:0] + k]) % NumVertices;
    w[0] = (65536 - ex) * (65536 - ey);
    w[1] = ex * (65536 - ey);
    w[2] = (65536 - ex) * ey;
    w[3] = ex * ey;
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int k = 0; k < 4; k++)
        acc += longint'($signed(vert_tab[Axes*vt[k] + j])) * w[k];
      p[j] = (acc + 64'sh8000_0000) >>> 32;
      r[j] = 0;
    end
    if (!proj_mode) begin
      for (int j = 0; j < 3; j++) r[j] = clamp24(p[j], sat);
      st = sat ? ST_SAT : ST_OK;
    end else begin
      n2 = 0;
      for (int j = 0; j < 3; j++) begin
        d[j] = p[j] - 32768;
        n2 += longint'(d[j] * d[j]);
      end
      if (n2 == 0) begin
        st = ST_ZERO;
      end else begin
        norm = int_sqrt(n2 << 16);
        for (int j = 0; j < 3; j++) begin
          mag  = (d[j] < 0) ? -d[j] : d[j];
          num  = (longint'(radius_q) * mag) << 8;
          q    = longint'((num + norm / 2) / norm);
          r[j] = clamp24((d[j] < 0) ? -q : q, sat);
        end
        st = sat ? ST_SAT : ST_OK;
      end
    end
    pt.x = r[0][23:0];
    pt.y = r[1][23:0];
    pt.z = r[2][23:0];
    pt.status = st;
    return pt;
  endfunction

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      proj_mode <= 1'b0;
      radius_q  <= RADIUS_RST;
      mapped_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:   proj_mode <= cfg_data[0];
          REG_RADIUS: radius_q  <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_VERT_WR: if (in_tdata[17:16] < 2'd3)
            vert_tab[Axes*in_tdata[15:8] + in_tdata[17:16]] <= in_tdata[41:18];
          OP_CORNER_WR: corner_tab[Corners*in_tdata[5:0] + in_tdata[7:6]] <= in_tdata[15:8];
          OP_MAP: mapped_q.push_back(map_point(in_tdata));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (mapped_q.size() == 0) begin
          report("unexpected word", out_tdata[23:0], 24'h0);
        end else begin
          want = mapped_q.pop_front();
          if (out_tdata[23:0] !== want.x) report("out_x", out_tdata[23:0], want.x);
          if (out_tdata[47:24] !== want.y) report("out_y", out_tdata[47:24], want.y);
          if (out_tdata[71:48] !== want.z) report("out_z", out_tdata[71:48], want.z);
          if (out_tuser !== want.status) report("status", {22'd0, out_tuser}, {22'd0, want.status});
        end
      end
    end
    pending = mapped_q.size();
  end

endmodule

>>> test/tb_bilinear_map_sphere_projection_unit.sv
// Testbench top: drives stimulus into the bilinear map unit and gives the verdict.
module tb_bilinear_map_sphere_projection_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bmsp_pkg::*;

  localparam int QuietLimit = 20000;
  localparam logic [1:0] OpUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_MAP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MODE;
  logic [23:0] cfg_data = '0;
  int          errors, pending;
  int          send_idle = 0, recv_stall = 0;
  logic        hold_off = 1'b0;
  int          quiet = 0;

  always #1 clk = ~clk;

  bilinear_map_sphere_projection_unit u_top (.*);

  bmsp_checker u_chk (.*);

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) out_tready <= !hold_off && ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("tb_bilinear_map_sphere_projection_unit: FAIL");
      $finish;
    end
  end

  function automatic logic [79:0] pack_word(logic [5:0] tree, logic [1:0] corner,
                                           logic [7:0] vidx, logic [1:0] comp,
                                           logic [23:0] val, logic [16:0] ex, logic [16:0] ey);
    return {4'd0, ey, ex, val, comp, vidx, corner, tree};
  endfunction

  task automatic send_word(logic [1:0] op, logic [79:0] word);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_vertex(logic [7:0] v, logic [1:0] comp, logic [23:0] val);
    send_word(OP_VERT_WR, pack_word(6'($urandom), 2'($urandom), v, comp, val,
                                    17'($urandom), 17'($urandom)));
  endtask

  task automatic write_corner(logic [5:0] t, logic [1:0] c, logic [7:0] v);
    send_word(OP_CORNER_WR, pack_word(t, c, v, 2'($urandom), 24'($urandom),
                                      17'($urandom), 17'($urandom)));
  endtask

  task automatic map_at(logic [5:0] t, logic [16:0] ex, logic [16:0] ey);
    send_word(OP_MAP, pack_word(t, 2'($urandom), 8'($urandom), 2'($urandom),
                                24'($urandom), ex, ey));
  endtask

  // drain, let the pipe empty, then write one register
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(1)) return 24'($urandom);
    return 24'($signed($urandom_range(524288)) - 262144);
  endfunction

  function automatic logic [16:0] rand_eta();
    if ($urandom_range(9) == 0) return 17'($urandom);
    return 17'($urandom_range(65536));
  endfunction

  task automatic directed_maps();
    map_at(6'd1, 17'd0, 17'd0);
    map_at(6'd1, ETA_ONE, ETA_ONE);
    map_at(6'd1, 17'h1FFFF, 17'd0);
    map_at(6'd1, 17'd0, 17'h1FFFF);
    map_at(6'd1, 17'd32768, 17'd32768);
    map_at(6'd0, 17'd12345, 17'd54321);    // all corners at the centre: zero norm
    map_at(6'd63, 17'($urandom), 17'($urandom));
    send_word(OpUnused, 80'($urandom));    // unused operation, dropped
    write_vertex(8'd200, 2'd3, 24'($urandom));  // axis three, dropped
  endtask

  task automatic random_items(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 65)
        map_at(6'($urandom), rand_eta(), rand_eta());
      else if (sel < 82)
        write_vertex(8'($urandom_range(255, 5)), 2'($urandom_range(2)), rand_coord());
      else if (sel < 96)
        write_corner(6'($urandom_range(63, 2)), 2'($urandom), 8'($urandom));
      else if (sel < 98)
        send_word(OpUnused, 80'({$urandom, $urandom, $urandom}));
      else
        write_vertex(8'($urandom), 2'd3, 24'($urandom));
    end
  endtask

  initial begin
    logic [23:0] rad;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // fill the tables; vertex 0 sits at the centre, vertex 1 at the extremes
    for (int v = 0; v < NumVertices; v++)
      for (int c = 0; c < Axes; c++)
        write_vertex(8'(v), 2'(c), (v == 0) ? 24'd32768 :
                           (v == 1) ? ((c == 0) ? S24_MIN : (c == 1) ? S24_MAX : 24'd0) :
                           rand_coord());
    for (int t = 0; t < NumTrees; t++)
      for (int c = 0; c < Corners; c++)
        write_corner(6'(t), 2'(c), (t == 0) ? 8'd0 : (t == 1) ? 8'(c + 1) : 8'($urandom));
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: rad = RADIUS_RST;
        1: rad = RADIUS_RST;
        2: rad = 24'hFF_FFFF;
        3: rad = 24'd0;
        default: rad = 24'($urandom);
      endcase
      if (ph > 0) begin
        write_reg(REG_MODE, (ph == 5) ? 24'd0 : 24'd1);
        write_reg(REG_RADIUS, rad);
      end
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      if (ph == 4) begin
        send_idle  = 0;
        recv_stall = 0;
      end
      directed_maps();
      random_items(70);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_bilinear_map_sphere_projection_unit: PASS");
    else
      $display("tb_bilinear_map_sphere_projection_unit: FAIL");
    $finish;
  end

  // hold the receiver off long enough for the pipe to fill and stall its input
  initial begin
    wait (rst_n && pending > 0 && send_idle == 0 && recv_stall == 0);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

endmodule

>>> bilinear_map_sphere_projection_unit.f
design/bmsp_pkg.sv
design/bilinear_map_sphere_projection_unit.sv
test/bmsp_checker.sv
test/tb_bilinear_map_sphere_projection_unit.sv
